@@ sv/lbcr_pkg.sv @@
// Shared types and constants for the largest balanced checker rectangle block.
package lbcr_pkg;

	localparam int MAX_ROWS_DEF   = 128;
	localparam int MAX_COLS_DEF   = 128;
	localparam int VALUE_BITS_DEF = 8;

	localparam int DIM_BITS      = 8;
	localparam int AREA_OUT_BITS = 15;
	localparam int PADDR_BITS    = 3;
	localparam int PDATA_BITS    = 32;

	typedef enum logic [0:0] {
		REG_GRID_HEIGHT = 1'b0,
		REG_GRID_WIDTH  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_R1_TOP,
		ST_R2_TOP,
		ST_NEXT_R2,
		ST_C1_TOP,
		ST_C1_WAIT,
		ST_C2_TOP,
		ST_C2_WAIT,
		ST_C2_EVAL,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RD_PREFETCH,
		RD_CORNER_CD,
		RD_CORNER_AB
	} rd_sel_t;

	typedef enum logic [1:0] {
		PM_FULL_ROW,
		PM_TAIL,
		PM_SPAN
	} pm_sel_t;

	typedef struct packed {
		logic    accept;
		logic    restart;
		logic    best_clr;
		logic    best_load;
		logic    r1_clr;
		logic    r1_inc;
		logic    r2_load;
		logic    r2_dec;
		logic    c1_clr;
		logic    c1_inc;
		logic    c2_load;
		logic    c2_dec;
		logic    cd_load;
		logic    sum_load;
		logic    emit;
		rd_sel_t rd_sel;
		pm_sel_t pm_sel;
	} cmd_t;

	typedef struct packed {
		logic last_cell;
		logic r1_end;
		logic r2_at_r1;
		logic c1_end;
		logic c2_at_c1;
		logic prod_le_best;
		logic sum_zero;
	} sts_t;

endpackage

@@ sv/lbcr_ctrl.sv @@
// Controller state machine: table load, corner search sequencing, result beat.
module lbcr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_stall,
	input  logic            cfg_wr,
	input  lbcr_pkg::sts_t  sts,
	output lbcr_pkg::cmd_t  cmd,
	output logic            in_stall,
	output logic            out_valid
);

	lbcr_pkg::state_t state_q;
	lbcr_pkg::state_t state_n;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			lbcr_pkg::ST_LOAD: begin
				if (in_valid && sts.last_cell) state_n = lbcr_pkg::ST_R1_TOP;
			end
			lbcr_pkg::ST_R1_TOP: begin
				if (sts.r1_end) state_n = lbcr_pkg::ST_EMIT;
				else state_n = lbcr_pkg::ST_R2_TOP;
			end
			lbcr_pkg::ST_R2_TOP: begin
				if (sts.prod_le_best) state_n = lbcr_pkg::ST_R1_TOP;
				else state_n = lbcr_pkg::ST_C1_TOP;
			end
			lbcr_pkg::ST_NEXT_R2: begin
				if (sts.r2_at_r1) state_n = lbcr_pkg::ST_R1_TOP;
				else state_n = lbcr_pkg::ST_R2_TOP;
			end
			lbcr_pkg::ST_C1_TOP: begin
				if (sts.c1_end || sts.prod_le_best) state_n = lbcr_pkg::ST_NEXT_R2;
				else state_n = lbcr_pkg::ST_C1_WAIT;
			end
			lbcr_pkg::ST_C1_WAIT: state_n = lbcr_pkg::ST_C2_TOP;
			lbcr_pkg::ST_C2_TOP: begin
				if (sts.prod_le_best) state_n = lbcr_pkg::ST_C1_TOP;
				else state_n = lbcr_pkg::ST_C2_WAIT;
			end
			lbcr_pkg::ST_C2_WAIT: state_n = lbcr_pkg::ST_C2_EVAL;
			lbcr_pkg::ST_C2_EVAL: begin
				if (sts.sum_zero || sts.c2_at_c1) state_n = lbcr_pkg::ST_C1_TOP;
				else state_n = lbcr_pkg::ST_C2_TOP;
			end
			lbcr_pkg::ST_EMIT: begin
				if (slot_free) state_n = lbcr_pkg::ST_LOAD;
			end
			default: state_n = lbcr_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = lbcr_pkg::RD_PREFETCH;
		cmd.pm_sel  = lbcr_pkg::PM_FULL_ROW;
		cmd.restart = cfg_wr;
		in_stall    = (state_q != lbcr_pkg::ST_LOAD);
		unique case (state_q)
			lbcr_pkg::ST_LOAD: begin
				cmd.accept = in_valid;
				if (in_valid && sts.last_cell) begin
					cmd.best_clr = 1'b1;
					cmd.r1_clr   = 1'b1;
				end
			end
			lbcr_pkg::ST_R1_TOP: begin
				if (!sts.r1_end) cmd.r2_load = 1'b1;
			end
			lbcr_pkg::ST_R2_TOP: begin
				cmd.pm_sel = lbcr_pkg::PM_FULL_ROW;
				if (sts.prod_le_best) cmd.r1_inc = 1'b1;
				else cmd.c1_clr = 1'b1;
			end
			lbcr_pkg::ST_NEXT_R2: begin
				if (sts.r2_at_r1) cmd.r1_inc = 1'b1;
				else cmd.r2_dec = 1'b1;
			end
			lbcr_pkg::ST_C1_TOP: begin
				cmd.pm_sel = lbcr_pkg::PM_TAIL;
				cmd.rd_sel = lbcr_pkg::RD_CORNER_CD;
			end
			lbcr_pkg::ST_C1_WAIT: begin
				cmd.cd_load = 1'b1;
				cmd.c2_load = 1'b1;
			end
			lbcr_pkg::ST_C2_TOP: begin
				cmd.pm_sel = lbcr_pkg::PM_SPAN;
				cmd.rd_sel = lbcr_pkg::RD_CORNER_AB;
				if (sts.prod_le_best) cmd.c1_inc = 1'b1;
			end
			lbcr_pkg::ST_C2_WAIT: begin
				cmd.sum_load = 1'b1;
			end
			lbcr_pkg::ST_C2_EVAL: begin
				cmd.pm_sel = lbcr_pkg::PM_SPAN;
				if (sts.sum_zero) begin
					cmd.best_load = 1'b1;
					cmd.c1_inc    = 1'b1;
				end else if (sts.c2_at_c1) begin
					cmd.c1_inc = 1'b1;
				end else begin
					cmd.c2_dec = 1'b1;
				end
			end
			lbcr_pkg::ST_EMIT: begin
				cmd.emit = slot_free;
			end
			default: begin
				cmd.accept = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lbcr_pkg::ST_LOAD;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_eval_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == lbcr_pkg::ST_C2_EVAL |-> $past(state_q) == lbcr_pkg::ST_C2_WAIT)
		else $error("corner sum evaluated without a fetch");
	a_beat_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == lbcr_pkg::ST_EMIT)
		else $error("result beat raised outside emit");
	a_search_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && sts.last_cell |=> state_q == lbcr_pkg::ST_R1_TOP)
		else $error("final cell did not start the search");
`endif

endmodule

@@ sv/lbcr_datapath.sv @@
// Datapath: summed-area table memory, load counters, corner counters, area compare.
module lbcr_datapath #(
	parameter int MAX_ROWS   = lbcr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = lbcr_pkg::MAX_COLS_DEF,
	parameter int VALUE_BITS = lbcr_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lbcr_pkg::cmd_t                        cmd,
	input  logic [$clog2(MAX_ROWS+1)-1:0]         h_dim,
	input  logic [$clog2(MAX_COLS+1)-1:0]         w_dim,
	input  logic [VALUE_BITS-1:0]                 cell_value,
	output lbcr_pkg::sts_t                        sts,
	output logic [lbcr_pkg::AREA_OUT_BITS-1:0]    largest_area
);

	localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AREA_W = $clog2(DEPTH + 1);
	localparam int PW     = RCW + CCW;
	localparam int SW     = VALUE_BITS + $clog2(DEPTH + 1) + 1;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		addr_of = AW'(r * MAX_COLS + c);
	endfunction

	logic signed [SW-1:0] mem [DEPTH];

	logic [RW-1:0]  lr_q, lr_n, r2_q, r1m1, h_m1;
	logic [CW-1:0]  lc_q, lc_n, c2_q, c1m1, w_m1;
	logic [RCW-1:0] r1_q, hh;
	logic [CCW-1:0] c1_q, span;
	logic [AW-1:0]  addr_wr, addr_pref, addr_a, addr_b;
	logic [PW-1:0]  prod;
	logic [AREA_W-1:0] best_q;
	logic [lbcr_pkg::AREA_OUT_BITS-1:0] largest_area_q;
	logic           byp_q, byp_n, par;
	logic signed [SW-1:0] rda_q, rdb_q, wdat_q, rowsum_q, rowsum_n, row_base, above;
	logic signed [SW-1:0] v_ext, v_signed, s_new, cval_q, dval_q, sum_q, b_term;

	always_comb begin
		h_m1 = RW'(h_dim - RCW'(1));
		w_m1 = CW'(w_dim - CCW'(1));

		lr_n = lr_q;
		lc_n = lc_q;
		if (cmd.restart) begin
			lr_n = '0;
			lc_n = '0;
		end else if (cmd.accept) begin
			if (lc_q == w_m1) begin
				lc_n = '0;
				lr_n = (lr_q == h_m1) ? '0 : RW'(lr_q + 1'b1);
			end else begin
				lc_n = CW'(lc_q + 1'b1);
			end
		end

		addr_wr   = addr_of(lr_q, lc_q);
		addr_pref = addr_of((lr_n == '0) ? '0 : RW'(lr_n - 1'b1), lc_n);
		byp_n     = cmd.accept && !cmd.restart && (lr_n != '0) && (addr_pref == addr_wr);

		v_ext    = SW'(cell_value);
		par      = lr_q[0] ^ lc_q[0];
		v_signed = par ? -v_ext : v_ext;
		row_base = (lc_q == '0) ? '0 : rowsum_q;
		rowsum_n = row_base + v_signed;
		above    = (lr_q == '0) ? '0 : (byp_q ? wdat_q : rda_q);
		s_new    = above + rowsum_n;

		r1m1 = (r1_q == '0) ? '0 : RW'(r1_q - 1'b1);
		c1m1 = (c1_q == '0) ? '0 : CW'(c1_q - 1'b1);

		unique case (cmd.rd_sel)
			lbcr_pkg::RD_PREFETCH: begin
				addr_a = addr_pref;
				addr_b = addr_pref;
			end
			lbcr_pkg::RD_CORNER_CD: begin
				addr_a = addr_of(r2_q, c1m1);
				addr_b = addr_of(r1m1, c1m1);
			end
			lbcr_pkg::RD_CORNER_AB: begin
				addr_a = addr_of(r2_q, c2_q);
				addr_b = addr_of(r1m1, c2_q);
			end
			default: begin
				addr_a = addr_pref;
				addr_b = addr_pref;
			end
		endcase

		hh = RCW'(RCW'(r2_q) - r1_q + RCW'(1));
		unique case (cmd.pm_sel)
			lbcr_pkg::PM_FULL_ROW: span = w_dim;
			lbcr_pkg::PM_TAIL:     span = CCW'(w_dim - c1_q);
			lbcr_pkg::PM_SPAN:     span = CCW'(CCW'(c2_q) - c1_q + CCW'(1));
			default:               span = w_dim;
		endcase
		prod = PW'(hh) * PW'(span);

		b_term = (r1_q == '0) ? '0 : rdb_q;

		sts.last_cell    = (lr_q == h_m1) && (lc_q == w_m1);
		sts.r1_end       = (r1_q >= h_dim);
		sts.r2_at_r1     = (RCW'(r2_q) == r1_q);
		sts.c1_end       = (c1_q >= w_dim);
		sts.c2_at_c1     = (CCW'(c2_q) == c1_q);
		sts.prod_le_best = (prod <= PW'(best_q));
		sts.sum_zero     = (sum_q == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= '0;
			lc_q   <= '0;
			byp_q  <= 1'b0;
			best_q <= '0;
			r1_q   <= '0;
			r2_q   <= '0;
			c1_q   <= '0;
			c2_q   <= '0;
		end else begin
			lr_q  <= lr_n;
			lc_q  <= lc_n;
			byp_q <= byp_n;
			if (cmd.best_clr) best_q <= '0;
			else if (cmd.best_load) best_q <= AREA_W'(prod);
			if (cmd.r1_clr) r1_q <= '0;
			else if (cmd.r1_inc) r1_q <= RCW'(r1_q + 1'b1);
			if (cmd.r2_load) r2_q <= h_m1;
			else if (cmd.r2_dec) r2_q <= RW'(r2_q - 1'b1);
			if (cmd.c1_clr) c1_q <= '0;
			else if (cmd.c1_inc) c1_q <= CCW'(c1_q + 1'b1);
			if (cmd.c2_load) c2_q <= w_m1;
			else if (cmd.c2_dec) c2_q <= CW'(c2_q - 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			wdat_q   <= s_new;
			rowsum_q <= rowsum_n;
		end
		if (cmd.cd_load) begin
			cval_q <= (c1_q == '0) ? '0 : rda_q;
			dval_q <= ((c1_q == '0) || (r1_q == '0)) ? '0 : rdb_q;
		end
		if (cmd.sum_load) sum_q <= rda_q - b_term - cval_q + dval_q;
		if (cmd.emit) largest_area_q <= lbcr_pkg::AREA_OUT_BITS'(best_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) mem[addr_wr] <= s_new;
		rda_q <= mem[addr_a];
		rdb_q <= mem[addr_b];
	end

	assign largest_area = largest_area_q;

`ifndef SYNTHESIS
	a_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> (RCW'(lr_q) < h_dim) && (CCW'(lc_q) < w_dim))
		else $error("table write outside the grid");
	a_best_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.best_load |-> !sts.prod_le_best)
		else $error("best area replaced by a smaller one");
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.best_clr |=> best_q >= $past(best_q))
		else $error("best area fell during search");
`endif

endmodule

@@ sv/largest_balanced_checker_rectangle.sv @@
// Top level of the largest balanced checker rectangle block: config registers and wiring.
// Cells stream in row-major order at one beat per cycle while the summed-area table
// fills; the table lives in one memory with a write port and two read ports, and a
// running row sum plus a prefetch of the cell above keep the load at full rate. After
// the final cell the input stalls while the corner search runs: every candidate right
// column fetches two corners, forms the sum and tests it, every left column first
// fetches its fixed corners, and each row pair is tested against the best area
// first; candidates that cannot beat the best area so far are skipped. The result
// beat waits in an output register, so the next grid may start loading before it is
// taken. The table needs no clearing after reset. Heights and widths of zero act as
// one and values above the maximum saturate; any register write restarts the grid.
module largest_balanced_checker_rectangle #(
	parameter int MAX_ROWS   = lbcr_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS   = lbcr_pkg::MAX_COLS_DEF,
	parameter int VALUE_BITS = lbcr_pkg::VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lbcr_pkg::PADDR_BITS-1:0]       paddr,
	input  logic [lbcr_pkg::PDATA_BITS-1:0]       pwdata,
	output logic [lbcr_pkg::PDATA_BITS-1:0]       prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [VALUE_BITS-1:0]                 cell_value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [lbcr_pkg::AREA_OUT_BITS-1:0]    largest_area
);

	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	logic [lbcr_pkg::DIM_BITS-1:0] grid_height_q, grid_width_q;
	logic [RCW-1:0]                h_dim;
	logic [CCW-1:0]                w_dim;
	logic                          cfg_wr;
	lbcr_pkg::reg_idx_t            reg_idx;
	lbcr_pkg::cmd_t                cmd;
	lbcr_pkg::sts_t                sts;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = lbcr_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_height_q <= lbcr_pkg::DIM_BITS'(1);
			grid_width_q  <= lbcr_pkg::DIM_BITS'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				lbcr_pkg::REG_GRID_HEIGHT: grid_height_q <= pwdata[lbcr_pkg::DIM_BITS-1:0];
				lbcr_pkg::REG_GRID_WIDTH:  grid_width_q  <= pwdata[lbcr_pkg::DIM_BITS-1:0];
				default: grid_height_q <= grid_height_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			lbcr_pkg::REG_GRID_HEIGHT: prdata = lbcr_pkg::PDATA_BITS'(grid_height_q);
			lbcr_pkg::REG_GRID_WIDTH:  prdata = lbcr_pkg::PDATA_BITS'(grid_width_q);
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		if (grid_height_q == '0) h_dim = RCW'(1);
		else if (32'(grid_height_q) > 32'(MAX_ROWS)) h_dim = RCW'(MAX_ROWS);
		else h_dim = RCW'(grid_height_q);
		if (grid_width_q == '0) w_dim = CCW'(1);
		else if (32'(grid_width_q) > 32'(MAX_COLS)) w_dim = CCW'(MAX_COLS);
		else w_dim = CCW'(grid_width_q);
	end

	lbcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.cfg_wr    (cfg_wr),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	lbcr_datapath #(
		.MAX_ROWS   (MAX_ROWS),
		.MAX_COLS   (MAX_COLS),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.h_dim        (h_dim),
		.w_dim        (w_dim),
		.cell_value   (cell_value),
		.sts          (sts),
		.largest_area (largest_area)
	);

endmodule
